>>> rtl/core/ivm_pkg.sv
// Shared constants, types and binary64 helper functions for the interval multiplier.
// No dependencies; used by ivm_fmul and interval_multiply_fp64.
package ivm_pkg;

  localparam logic [63:0] QNAN_BITS  = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] EXP_INF    = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] MAX_FINITE = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam int          FMUL_LAT   = 4;

  typedef enum logic [1:0] {
    CLS_POS,
    CLS_STR,
    CLS_NEG
  } class_e;

  typedef struct packed {
    logic [52:0]        m;
    logic signed [11:0] e;
  } unpk_t;

  function automatic logic is_nan(input logic [63:0] x);
    return x[62:0] > EXP_INF[62:0];
  endfunction

  function automatic logic is_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  function automatic logic is_inf(input logic [63:0] x);
    return x[62:0] == EXP_INF[62:0];
  endfunction

  function automatic class_e class_of(input logic [63:0] lo, input logic [63:0] hi);
    logic ge_lo, lt_lo, gt_hi;
    ge_lo = !is_nan(lo) && (!lo[63] || is_zero(lo));
    lt_lo = !is_nan(lo) && lo[63] && !is_zero(lo);
    gt_hi = !is_nan(hi) && !hi[63] && !is_zero(hi);
    if (ge_lo) return CLS_POS;
    if (lt_lo && gt_hi) return CLS_STR;
    return CLS_NEG;
  endfunction

  function automatic logic [63:0] order_key(input logic [63:0] x);
    return x[63] ? ~x : {1'b1, x[62:0]};
  endfunction

endpackage

>>> rtl/core/ivm_fmul.sv
// Four-stage binary64 multiplier with directed rounding (toward +inf or -inf).
// Depends on ivm_pkg; all stages advance together on en_i.
module ivm_fmul import ivm_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  input  logic        up_i,
  output logic [63:0] res_o
);

  function automatic unpk_t unpack(input logic [63:0] x);
    unpk_t      r;
    logic [5:0] pos;
    logic [5:0] sh;
    pos = '0;
    for (int i = 0; i < 52; i++) begin
      if (x[i]) pos = 6'(i);
    end
    sh = 6'd52 - pos;
    if (x[62:52] == 11'd0) begin
      r.m = {1'b0, x[51:0]} << sh;
      r.e = 12'sd1 - $signed({6'b0, sh});
    end else begin
      r.m = {1'b1, x[51:0]};
      r.e = $signed({1'b0, x[62:52]});
    end
    return r;
  endfunction

  // stage 1: specials, unpack
  logic               sign_d, away_d, spec_d;
  logic [63:0]        spec_val_d;
  unpk_t              ua, ub;
  logic signed [13:0] be_d;

  logic               s1_sign_q, s1_away_q, s1_spec_q;
  logic [63:0]        s1_spec_val_q;
  logic [52:0]        s1_ma_q, s1_mb_q;
  logic signed [13:0] s1_be_q;

  always_comb begin
    sign_d     = x_i[63] ^ y_i[63];
    away_d     = up_i ? !sign_d : sign_d;
    spec_d     = 1'b1;
    spec_val_d = QNAN_BITS;
    if (is_nan(x_i) || is_nan(y_i)) begin
      spec_val_d = QNAN_BITS;
    end else if (is_inf(x_i) || is_inf(y_i)) begin
      spec_val_d = (is_zero(x_i) || is_zero(y_i)) ? QNAN_BITS : {sign_d, EXP_INF[62:0]};
    end else if (is_zero(x_i) || is_zero(y_i)) begin
      spec_val_d = {sign_d, 63'd0};
    end else begin
      spec_d = 1'b0;
    end
    ua   = unpack(x_i);
    ub   = unpack(y_i);
    be_d = {{2{ua.e[11]}}, ua.e} + {{2{ub.e[11]}}, ub.e} - 14'sd1022;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q     <= sign_d;
      s1_away_q     <= away_d;
      s1_spec_q     <= spec_d;
      s1_spec_val_q <= spec_val_d;
      s1_ma_q       <= ua.m;
      s1_mb_q       <= ub.m;
      s1_be_q       <= be_d;
    end
  end

  // stage 2: partial products
  logic               s2_sign_q, s2_away_q, s2_spec_q;
  logic [63:0]        s2_spec_val_q;
  logic signed [13:0] s2_be_q;
  logic [53:0]        pp_ll_q;
  logic [52:0]        pp_lh_q, pp_hl_q;
  logic [51:0]        pp_hh_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q     <= s1_sign_q;
      s2_away_q     <= s1_away_q;
      s2_spec_q     <= s1_spec_q;
      s2_spec_val_q <= s1_spec_val_q;
      s2_be_q       <= s1_be_q;
      pp_ll_q       <= s1_ma_q[26:0] * s1_mb_q[26:0];
      pp_lh_q       <= s1_ma_q[26:0] * s1_mb_q[52:27];
      pp_hl_q       <= s1_ma_q[52:27] * s1_mb_q[26:0];
      pp_hh_q       <= s1_ma_q[52:27] * s1_mb_q[52:27];
    end
  end

  // stage 3: sum and normalize
  logic [105:0]       prod;
  logic [63:0]        q_d;
  logic signed [13:0] be3_d;

  logic               s3_sign_q, s3_away_q, s3_spec_q;
  logic [63:0]        s3_spec_val_q;
  logic signed [13:0] s3_be_q;
  logic [63:0]        s3_q_q;

  always_comb begin
    prod  = (106'(pp_hh_q) << 54) + (106'(pp_lh_q) << 27) + (106'(pp_hl_q) << 27)
          + 106'(pp_ll_q);
    q_d   = prod[105:42] | {63'd0, |prod[41:0]};
    be3_d = s2_be_q;
    if (!q_d[63]) begin
      q_d   = q_d << 1;
      be3_d = s2_be_q - 14'sd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sign_q     <= s2_sign_q;
      s3_away_q     <= s2_away_q;
      s3_spec_q     <= s2_spec_q;
      s3_spec_val_q <= s2_spec_val_q;
      s3_be_q       <= be3_d;
      s3_q_q        <= q_d;
    end
  end

  // stage 4: round
  logic [63:0]        res_d, sig, sum;
  logic               inexact;
  logic signed [13:0] be_m1, rs;
  logic [63:0]        res_q;

  always_comb begin
    be_m1   = s3_be_q - 14'sd1;
    rs      = 14'sd12 - s3_be_q;
    sig     = '0;
    inexact = 1'b0;
    sum     = '0;
    if (s3_spec_q) begin
      res_d = s3_spec_val_q;
    end else if (s3_be_q >= 14'sd2047) begin
      res_d = {s3_sign_q, s3_away_q ? EXP_INF[62:0] : MAX_FINITE[62:0]};
    end else if (s3_be_q >= 14'sd1) begin
      sig     = {11'd0, s3_q_q[63:11]};
      inexact = |s3_q_q[10:0];
      sum     = {1'b0, be_m1[10:0], 52'd0} + sig + {63'd0, inexact && s3_away_q};
      res_d   = sum | {s3_sign_q, 63'd0};
    end else begin
      if (rs >= 14'sd64) begin
        sig     = '0;
        inexact = 1'b1;
      end else begin
        sig     = s3_q_q >> rs[5:0];
        inexact = |(s3_q_q & ((64'd1 << rs[5:0]) - 64'd1));
      end
      sum   = sig + {63'd0, inexact && s3_away_q};
      res_d = sum | {s3_sign_q, 63'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/core/interval_multiply_fp64.sv
// Interval product of two binary64 intervals [a_low, a_high] x [b_low, b_high].
// The block accepts one transaction per cycle while in_stall_o is low. Each result passes
// through the input register (loaded at the accepting edge), four multiplier stages and
// the min/max output register. The 53x53 significand multiply is split into four partial
// products of 27-bit and 26-bit halves. A one-entry skid buffer at the output takes a
// stalled result while the pipeline advances; in_stall_o rises only while that buffer
// is occupied, and the pipeline holds until it empties. Lower bounds round toward -inf,
// upper toward +inf; zero times infinity and NaN operands give the quiet NaN pattern.
// Depends on ivm_pkg and ivm_fmul.
module interval_multiply_fp64 import ivm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] a_low_bits_i,
  input  logic [63:0] a_high_bits_i,
  input  logic        a_is_empty_i,
  input  logic [63:0] b_low_bits_i,
  input  logic [63:0] b_high_bits_i,
  input  logic        b_is_empty_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] prod_low_bits_o,
  output logic [63:0] prod_high_bits_o,
  output logic        prod_is_empty_o
);

  localparam int VLEN = FMUL_LAT + 2;

  logic             skid_q;
  logic             adv;
  logic [VLEN-1:0]  v_q;
  logic [FMUL_LAT:0] emp_q;

  logic [63:0] al_q, ah_q, bl_q, bh_q;

  assign adv        = !skid_q;
  assign in_stall_o = skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[VLEN-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      al_q  <= a_low_bits_i;
      ah_q  <= a_high_bits_i;
      bl_q  <= b_low_bits_i;
      bh_q  <= b_high_bits_i;
      emp_q <= {emp_q[FMUL_LAT-1:0], a_is_empty_i | b_is_empty_i};
    end
  end

  // operand selection by sign class
  class_e      ca, cb;
  logic [63:0] m0x, m0y, m1x, m1y, m2x, m2y, m3x, m3y;

  always_comb begin
    ca  = class_of(al_q, ah_q);
    cb  = class_of(bl_q, bh_q);
    m0x = ah_q; m0y = bh_q;
    m2x = al_q; m2y = bl_q;
    case (ca)
      CLS_POS: begin
        case (cb)
          CLS_POS: begin m0x = al_q; m0y = bl_q; m2x = ah_q; m2y = bh_q; end
          CLS_STR: begin m0x = ah_q; m0y = bl_q; m2x = ah_q; m2y = bh_q; end
          default: begin m0x = ah_q; m0y = bl_q; m2x = al_q; m2y = bh_q; end
        endcase
      end
      CLS_STR: begin
        case (cb)
          CLS_POS: begin m0x = al_q; m0y = bh_q; m2x = ah_q; m2y = bh_q; end
          CLS_STR: begin m0x = al_q; m0y = bh_q; m2x = al_q; m2y = bl_q; end
          default: begin m0x = ah_q; m0y = bl_q; m2x = al_q; m2y = bl_q; end
        endcase
      end
      default: begin
        case (cb)
          CLS_POS: begin m0x = al_q; m0y = bh_q; m2x = ah_q; m2y = bl_q; end
          CLS_STR: begin m0x = al_q; m0y = bh_q; m2x = al_q; m2y = bl_q; end
          default: begin m0x = ah_q; m0y = bh_q; m2x = al_q; m2y = bl_q; end
        endcase
      end
    endcase
    m1x = m0x; m1y = m0y;
    m3x = m2x; m3y = m2y;
    if (ca == CLS_STR && cb == CLS_STR) begin
      m1x = ah_q; m1y = bl_q;
      m3x = ah_q; m3y = bh_q;
    end
  end

  logic [63:0] r0, r1, r2, r3;

  ivm_fmul u_lo0 (.clk_i, .en_i(adv), .x_i(m0x), .y_i(m0y), .up_i(1'b0), .res_o(r0));
  ivm_fmul u_lo1 (.clk_i, .en_i(adv), .x_i(m1x), .y_i(m1y), .up_i(1'b0), .res_o(r1));
  ivm_fmul u_hi0 (.clk_i, .en_i(adv), .x_i(m2x), .y_i(m2y), .up_i(1'b1), .res_o(r2));
  ivm_fmul u_hi1 (.clk_i, .en_i(adv), .x_i(m3x), .y_i(m3y), .up_i(1'b1), .res_o(r3));

  // min/max and output register
  logic [63:0] lo_d, hi_d, lo_q, hi_q, skid_lo_q, skid_hi_q;
  logic        emp_out_q, skid_emp_q;

  always_comb begin
    lo_d = (order_key(r1) < order_key(r0)) ? r1 : r0;
    hi_d = (order_key(r3) > order_key(r2)) ? r3 : r2;
    if (emp_q[FMUL_LAT]) begin
      lo_d = '0;
      hi_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      emp_out_q <= emp_q[FMUL_LAT];
    end
    if (adv && v_q[VLEN-1] && out_stall_i) begin
      skid_lo_q  <= lo_q;
      skid_hi_q  <= hi_q;
      skid_emp_q <= emp_out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (skid_q) begin
      if (!out_stall_i) skid_q <= 1'b0;
    end else if (v_q[VLEN-1] && out_stall_i) begin
      skid_q <= 1'b1;
    end
  end

  assign out_valid_o      = skid_q | v_q[VLEN-1];
  assign prod_low_bits_o  = skid_q ? skid_lo_q : lo_q;
  assign prod_high_bits_o = skid_q ? skid_hi_q : hi_q;
  assign prod_is_empty_o  = skid_q ? skid_emp_q : emp_out_q;

  a_skid_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_o) else $error("skid entry not presented");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q && out_stall_i) |=> skid_q) else $error("skid entry dropped while stalled");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_q) |-> $past(v_q[VLEN-1] && out_stall_i)) else $error("skid filled without cause");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && prod_is_empty_o) |-> (prod_low_bits_o == 64'd0 && prod_high_bits_o == 64'd0))
    else $error("empty result with nonzero bounds");

endmodule

>>> tb/tb_interval_multiply_fp64.sv
// Self-checking testbench for interval_multiply_fp64: random and directed interval pairs,
// expected products computed by a bit-exact directed-rounding binary64 multiplier model.
// Depends on ivm_pkg (class_e) and the interval_multiply_fp64 RTL.
`timescale 1ns / 1ps
module tb_interval_multiply_fp64 import ivm_pkg::*;;

  typedef struct packed {
    logic [63:0] al, ah;
    logic        ae;
    logic [63:0] bl, bh;
    logic        be;
  } ivl_pair_t;

  typedef struct packed {
    logic [63:0] lo, hi;
    logic        empty;
  } ivl_prod_t;

  localparam logic [63:0] SGN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QNAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] MAXF = 64'h7FEF_FFFF_FFFF_FFFF;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o;
  logic [63:0] a_low_bits_i = 0, a_high_bits_i = 0, b_low_bits_i = 0, b_high_bits_i = 0;
  logic a_is_empty_i = 0, b_is_empty_i = 0;
  logic out_valid_o, out_stall_i = 0;
  logic [63:0] prod_low_bits_o, prod_high_bits_o;
  logic prod_is_empty_o;

  ivl_pair_t pending_q[$];
  ivl_prod_t expected_q[$];
  int err_cnt = 0;
  bit calm = 0;
  bit in_acc = 0;

  interval_multiply_fp64 uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic bit f_nan(logic [63:0] x);
    return x[62:0] > INF[62:0];
  endfunction
  function automatic bit f_zero(logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction
  function automatic bit f_inf(logic [63:0] x);
    return x[62:0] == INF[62:0];
  endfunction
  function automatic logic [63:0] okey(logic [63:0] x);
    return x[63] ? ~x : (x | SGN);
  endfunction

  function automatic logic [63:0] mul_round(logic [63:0] x, logic [63:0] y, bit up);
    logic [63:0] s, q, sig;
    logic [52:0] ma, mb;
    logic [105:0] p;
    int ea, eb, bexp, rs;
    bit away, inx;
    s = (x ^ y) & SGN;
    away = up ? (s == 64'd0) : (s != 64'd0);
    if (f_nan(x) || f_nan(y)) return QNAN;
    if (f_inf(x) || f_inf(y)) return (f_zero(x) || f_zero(y)) ? QNAN : (s | INF);
    if (f_zero(x) || f_zero(y)) return s;
    ea = int'(x[62:52]); ma = {1'b0, x[51:0]};
    if (ea == 0) begin ea = 1; while (!ma[52]) begin ma = ma << 1; ea--; end end
    else ma[52] = 1'b1;
    eb = int'(y[62:52]); mb = {1'b0, y[51:0]};
    if (eb == 0) begin eb = 1; while (!mb[52]) begin mb = mb << 1; eb--; end end
    else mb[52] = 1'b1;
    p = 106'(ma) * 106'(mb);
    q = p[105:42] | {63'd0, |p[41:0]};
    bexp = ea + eb - 1022;
    if (!q[63]) begin q = q << 1; bexp--; end
    if (bexp >= 2047) return s | (away ? INF : MAXF);
    if (bexp >= 1) begin
      sig = q >> 11; inx = q[10:0] != 11'd0;
      if (inx && away) sig++;
      return s | ((64'(bexp - 1) << 52) + sig);
    end
    rs = 12 - bexp;
    if (rs >= 64) begin sig = '0; inx = 1; end
    else begin sig = q >> rs; inx = (q & ((64'd1 << rs) - 64'd1)) != 64'd0; end
    if (inx && away) sig++;
    return s | sig;
  endfunction

  function automatic class_e sign_class(logic [63:0] lo, logic [63:0] hi);
    if (!f_nan(lo) && (!lo[63] || f_zero(lo))) return CLS_POS;
    if (!f_nan(lo) && lo[63] && !f_zero(lo) && !f_nan(hi) && !hi[63] && !f_zero(hi))
      return CLS_STR;
    return CLS_NEG;
  endfunction

  function automatic ivl_prod_t interval_product(ivl_pair_t t);
    ivl_prod_t r;
    logic [63:0] c0, c1;
    r = '0;
    if (t.ae || t.be) begin r.empty = 1; return r; end
    case ({sign_class(t.al, t.ah), sign_class(t.bl, t.bh)})
      {CLS_POS, CLS_POS}: begin r.lo = mul_round(t.al, t.bl, 0); r.hi = mul_round(t.ah, t.bh, 1); end
      {CLS_POS, CLS_STR}: begin r.lo = mul_round(t.ah, t.bl, 0); r.hi = mul_round(t.ah, t.bh, 1); end
      {CLS_POS, CLS_NEG}: begin r.lo = mul_round(t.ah, t.bl, 0); r.hi = mul_round(t.al, t.bh, 1); end
      {CLS_STR, CLS_POS}: begin r.lo = mul_round(t.al, t.bh, 0); r.hi = mul_round(t.ah, t.bh, 1); end
      {CLS_STR, CLS_STR}: begin
        c0 = mul_round(t.al, t.bh, 0); c1 = mul_round(t.ah, t.bl, 0);
        r.lo = (okey(c1) < okey(c0)) ? c1 : c0;
        c0 = mul_round(t.al, t.bl, 1); c1 = mul_round(t.ah, t.bh, 1);
        r.hi = (okey(c1) > okey(c0)) ? c1 : c0;
      end
      {CLS_STR, CLS_NEG}: begin r.lo = mul_round(t.ah, t.bl, 0); r.hi = mul_round(t.al, t.bl, 1); end
      {CLS_NEG, CLS_POS}: begin r.lo = mul_round(t.al, t.bh, 0); r.hi = mul_round(t.ah, t.bl, 1); end
      {CLS_NEG, CLS_STR}: begin r.lo = mul_round(t.al, t.bh, 0); r.hi = mul_round(t.al, t.bl, 1); end
      default:            begin r.lo = mul_round(t.ah, t.bh, 0); r.hi = mul_round(t.al, t.bl, 1); end
    endcase
    return r;
  endfunction

  // mostly ordinary values, with zeros, infinities, NaNs, subnormals and extremes mixed in
  function automatic logic [63:0] rand_fp(bit neg);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: v[62:0] = '0;
      1: v[62:0] = INF[62:0];
      2: v[62:52] = 11'h7FF;
      3: v[62:52] = 11'd0;
      4: v[62:0] = MAXF[62:0];
      5: v[62:52] = 11'($urandom_range(1900, 2046));
      6: v[62:52] = 11'($urandom_range(1, 150));
      7: ;
      default: v[62:52] = 11'($urandom_range(900, 1150));
    endcase
    if ($urandom_range(0, 9) != 0) v[63] = neg;
    return v;
  endfunction

  function automatic void rand_ivl(output logic [63:0] lo, output logic [63:0] hi);
    case ($urandom_range(0, 3))
      0: begin lo = rand_fp(0); hi = rand_fp(0); end
      1: begin lo = rand_fp(1); hi = rand_fp(0); end
      2: begin lo = rand_fp(1); hi = rand_fp(1); end
      default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] exp_v);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    err_cnt++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_acc) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
          ivl_pair_t t;
          t = pending_q.pop_front();
          in_valid_i <= 1;
          a_low_bits_i <= t.al; a_high_bits_i <= t.ah; a_is_empty_i <= t.ae;
          b_low_bits_i <= t.bl; b_high_bits_i <= t.bh; b_is_empty_i <= t.be;
        end else begin
          in_valid_i <= 0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  always @(posedge clk_i) begin
    in_acc = in_valid_i && !in_stall_o;
    if (in_acc)
      expected_q.push_back(interval_product({a_low_bits_i, a_high_bits_i, a_is_empty_i,
                                             b_low_bits_i, b_high_bits_i, b_is_empty_i}));
    if (out_valid_o && !out_stall_i) begin
      ivl_prod_t e;
      if (expected_q.size() == 0) begin
        report("unexpected transaction", prod_low_bits_o, 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (prod_low_bits_o !== e.lo) report("prod_low_bits", prod_low_bits_o, e.lo);
        if (prod_high_bits_o !== e.hi) report("prod_high_bits", prod_high_bits_o, e.hi);
        if (prod_is_empty_o !== e.empty)
          report("prod_is_empty", {63'd0, prod_is_empty_o}, {63'd0, e.empty});
      end
    end
  end

  initial begin
    logic [63:0] v[16];
    ivl_pair_t t;
    v = '{64'h0, SGN, INF, SGN | INF, QNAN, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
          MAXF, SGN | MAXF, 64'h1, SGN | 64'h1, 64'h000F_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF8_0000_0000_0001, 64'hC000_0000_0000_0003,
          64'h7FF0_0000_0000_0001};
    // empties, straddle/straddle, zero times infinity, overflow, underflow, NaN, reversed
    pending_q.push_back({v[5], v[5], 1'b1, v[5], v[5], 1'b0});
    pending_q.push_back({v[5], v[5], 1'b0, v[5], v[5], 1'b1});
    pending_q.push_back({v[6], v[5], 1'b0, v[14], v[13], 1'b0});
    pending_q.push_back({v[0], v[2], 1'b0, v[3], v[0], 1'b0});
    pending_q.push_back({v[1], v[2], 1'b0, v[3], v[2], 1'b0});
    pending_q.push_back({v[7], v[7], 1'b0, v[7], v[7], 1'b0});
    pending_q.push_back({v[8], v[8], 1'b0, v[7], v[7], 1'b0});
    pending_q.push_back({v[9], v[9], 1'b0, v[9], v[11], 1'b0});
    pending_q.push_back({v[10], v[9], 1'b0, v[10], v[9], 1'b0});
    pending_q.push_back({v[4], v[5], 1'b0, v[5], v[13], 1'b0});
    pending_q.push_back({v[6], v[4], 1'b0, v[14], v[12], 1'b0});
    pending_q.push_back({v[13], v[14], 1'b0, v[6], v[14], 1'b0});
    pending_q.push_back({v[14], v[6], 1'b0, v[8], v[3], 1'b0});
    pending_q.push_back({v[15], v[15], 1'b0, v[0], v[1], 1'b0});
    pending_q.push_back({v[12], v[12], 1'b1, v[12], v[12], 1'b1});
    pending_q.push_back({v[13], v[13], 1'b0, v[6], v[13], 1'b0});
    pending_q.push_back({v[14], v[14], 1'b0, v[6], v[5], 1'b0});
    for (int i = 0; i < 400; i++) begin
      rand_ivl(t.al, t.ah);
      rand_ivl(t.bl, t.bh);
      t.ae = ($urandom_range(0, 19) == 0);
      t.be = ($urandom_range(0, 19) == 0);
      pending_q.push_back(t);
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;
    wait (pending_q.size() < 200);
    calm = 1;
    wait (pending_q.size() < 120);
    calm = 0;
    wait (pending_q.size() == 0 && !in_valid_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0)
      $display("[interval_multiply_fp64] OK");
    else
      $display("[interval_multiply_fp64] ERROR");
    $finish;
  end

  initial begin
    #1ms;
    $display("[interval_multiply_fp64] ERROR");
    $finish;
  end

endmodule
